/* src/sbrd_pkg.sv */
// ----------------------------------------------------------------------------
// sbrd_pkg
// Shared types and constants for the servo bus response deframer.
// ----------------------------------------------------------------------------
package sbrd_pkg;

	localparam int BUFFER_BYTES = 16;
	localparam int PARAM_MAX    = BUFFER_BYTES - 4;
	localparam int PIDX_W       = $clog2(PARAM_MAX);
	localparam int PCNT_W       = $clog2(PARAM_MAX + 1);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0]  SYNC_BYTE     = 8'h55;
	localparam logic [7:0]  LEN_OVERHEAD  = 8'd3;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam int          ADDR_W      = 3;
	localparam logic [0:0]  REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HEADER,
		PH_HEAD,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		OUT_OK       = 2'd0,
		OUT_TIMEOUT  = 2'd1,
		OUT_BADLEN   = 2'd2,
		OUT_MISMATCH = 2'd3
	} outcome_t;

	// One finished transaction handed from the front to the back.
	typedef struct packed {
		outcome_t                        outcome;
		logic [7:0]                      id;
		logic [PCNT_W-1:0]               count;
		logic [7:0]                      checksum;
		logic [PARAM_MAX-1:0][7:0]       params;
	} job_t;

endpackage

/* src/sbrd_front.sv */
// ----------------------------------------------------------------------------
// sbrd_front
// Receive side: accepts items, walks the reply phases and queues a job
// when a transaction ends.
// ----------------------------------------------------------------------------
module sbrd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          expected_command,
	input  logic [15:0]         timeout_ticks,
	input  logic                q_full,
	output logic                push,
	output sbrd_pkg::job_t      job
);

	sbrd_pkg::phase_t phase_q, phase_nx;
	logic                        hdr_one_q, hdr_one_nx;
	logic [15:0]                 timer_q, timer_nx, timer_inc;
	logic [7:0]                  want_q, want_nx;
	logic [7:0]                  id_q, id_nx;
	logic [7:0]                  len_q, len_nx;
	logic [7:0]                  cmd_q, cmd_nx;
	logic [sbrd_pkg::PCNT_W-1:0] taken_q, taken_nx;
	logic [sbrd_pkg::PCNT_W-1:0] plen_q, plen_nx;
	logic [7:0]                  store_q [sbrd_pkg::PARAM_MAX];

	logic       accept;
	logic       active;
	logic       is_byte;
	logic       is_tick;
	logic [7:0] plen8;
	logic       expire;
	logic       badlen;
	logic       body_end;
	logic       store_we;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign active    = accept && (phase_q != sbrd_pkg::PH_IDLE);
	assign is_byte   = active && (action == sbrd_pkg::ACT_BYTE);
	assign is_tick   = active && (action == sbrd_pkg::ACT_TICK);
	assign timer_inc = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;
	assign expire    = is_tick && (timer_inc >= timeout_ticks);
	assign plen8     = len_q - sbrd_pkg::LEN_OVERHEAD;
	assign badlen    = is_byte && (phase_q == sbrd_pkg::PH_HEAD) &&
		(taken_q == sbrd_pkg::PCNT_W'(2)) && (plen8 > 8'(sbrd_pkg::PARAM_MAX));
	assign body_end  = is_byte && (phase_q == sbrd_pkg::PH_BODY) && !(taken_q < plen_q);
	assign store_we  = is_byte && (phase_q == sbrd_pkg::PH_BODY) && (taken_q < plen_q);

	// Next state.
	always_comb begin
		phase_nx   = phase_q;
		hdr_one_nx = hdr_one_q;
		timer_nx   = timer_q;
		want_nx    = want_q;
		id_nx      = id_q;
		len_nx     = len_q;
		cmd_nx     = cmd_q;
		taken_nx   = taken_q;
		plen_nx    = plen_q;
		if (accept && action == sbrd_pkg::ACT_START) begin
			phase_nx   = sbrd_pkg::PH_HEADER;
			hdr_one_nx = 1'b0;
			timer_nx   = '0;
			want_nx    = expected_command;
			id_nx      = '0;
			len_nx     = '0;
			cmd_nx     = '0;
			taken_nx   = '0;
		end else if (is_tick) begin
			timer_nx = timer_inc;
			if (expire) begin
				phase_nx = sbrd_pkg::PH_IDLE;
			end
		end else if (is_byte) begin
			case (phase_q)
				sbrd_pkg::PH_HEADER: begin
					if (rx_byte == sbrd_pkg::SYNC_BYTE) begin
						if (hdr_one_q) begin
							phase_nx = sbrd_pkg::PH_HEAD;
							timer_nx = '0;
							taken_nx = '0;
						end else begin
							hdr_one_nx = 1'b1;
						end
					end else begin
						hdr_one_nx = 1'b0;
					end
				end
				sbrd_pkg::PH_HEAD: begin
					if (taken_q == '0) begin
						id_nx    = rx_byte;
						taken_nx = sbrd_pkg::PCNT_W'(1);
					end else if (taken_q == sbrd_pkg::PCNT_W'(1)) begin
						len_nx   = rx_byte;
						taken_nx = sbrd_pkg::PCNT_W'(2);
					end else begin
						cmd_nx = rx_byte;
						if (badlen) begin
							phase_nx = sbrd_pkg::PH_IDLE;
						end else begin
							phase_nx = sbrd_pkg::PH_BODY;
							timer_nx = '0;
							taken_nx = '0;
							plen_nx  = plen8[sbrd_pkg::PCNT_W-1:0];
						end
					end
				end
				sbrd_pkg::PH_BODY: begin
					if (store_we) begin
						taken_nx = taken_q + sbrd_pkg::PCNT_W'(1);
					end else begin
						phase_nx = sbrd_pkg::PH_IDLE;
					end
				end
				default: begin
					phase_nx = phase_q;
				end
			endcase
		end
	end

	// Job for the back end.
	always_comb begin
		push         = expire || badlen || body_end;
		job.outcome  = sbrd_pkg::OUT_OK;
		job.id       = id_q;
		job.count    = '0;
		job.checksum = '0;
		for (int i = 0; i < sbrd_pkg::PARAM_MAX; i++) begin
			job.params[i] = store_q[i];
		end
		if (expire) begin
			job.outcome = sbrd_pkg::OUT_TIMEOUT;
		end else if (badlen) begin
			job.outcome = sbrd_pkg::OUT_BADLEN;
		end else if (cmd_q != want_q) begin
			job.outcome  = sbrd_pkg::OUT_MISMATCH;
			job.checksum = rx_byte;
		end else begin
			job.count    = plen_q;
			job.checksum = rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sbrd_pkg::PH_IDLE;
			hdr_one_q <= 1'b0;
			timer_q   <= '0;
			want_q    <= '0;
			id_q      <= '0;
			len_q     <= '0;
			cmd_q     <= '0;
			taken_q   <= '0;
			plen_q    <= '0;
		end else begin
			phase_q   <= phase_nx;
			hdr_one_q <= hdr_one_nx;
			timer_q   <= timer_nx;
			want_q    <= want_nx;
			id_q      <= id_nx;
			len_q     <= len_nx;
			cmd_q     <= cmd_nx;
			taken_q   <= taken_nx;
			plen_q    <= plen_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[taken_q[sbrd_pkg::PIDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

/* src/sbrd_queue.sv */
// ----------------------------------------------------------------------------
// sbrd_queue
// Short job queue between the receive front and the result back end.
// ----------------------------------------------------------------------------
module sbrd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbrd_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           rd_valid,
	output sbrd_pkg::job_t rd_job
);

	sbrd_pkg::job_t              entry_q [sbrd_pkg::QUEUE_DEPTH];
	logic [sbrd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sbrd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sbrd_pkg::QCNT_W-1:0] count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full     = (count_q == sbrd_pkg::QCNT_W'(sbrd_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == sbrd_pkg::QPTR_W'(sbrd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + sbrd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == sbrd_pkg::QPTR_W'(sbrd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + sbrd_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + sbrd_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - sbrd_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

/* src/sbrd_back.sv */
// ----------------------------------------------------------------------------
// sbrd_back
// Result side: takes one job at a time and plays out its parameter bytes
// followed by the status result through an output register.
// ----------------------------------------------------------------------------
module sbrd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  sbrd_pkg::job_t              q_job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        is_status,
	output logic [7:0]                  param_value,
	output logic [sbrd_pkg::PIDX_W-1:0] param_index,
	output logic [1:0]                  outcome,
	output logic [7:0]                  reply_id,
	output logic [sbrd_pkg::PCNT_W-1:0] reply_param_count,
	output logic [7:0]                  reply_checksum,
	output logic                        last
);

	sbrd_pkg::job_t              job_q;
	logic                        job_valid_q;
	logic [sbrd_pkg::PCNT_W-1:0] idx_q;
	logic                        out_valid_q;
	logic                        slot_free;
	logic                        emit;
	logic                        emit_param;

	assign slot_free  = !out_valid_q || out_ready;
	assign pop        = !job_valid_q && q_valid;
	assign emit       = job_valid_q && slot_free;
	assign emit_param = idx_q < job_q.count;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit) begin
				if (emit_param) begin
					idx_q <= idx_q + sbrd_pkg::PCNT_W'(1);
				end else begin
					job_valid_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			if (emit_param) begin
				is_status         <= 1'b0;
				param_value       <= job_q.params[idx_q[sbrd_pkg::PIDX_W-1:0]];
				param_index       <= idx_q[sbrd_pkg::PIDX_W-1:0];
				outcome           <= sbrd_pkg::OUT_OK;
				reply_id          <= '0;
				reply_param_count <= '0;
				reply_checksum    <= '0;
				last              <= 1'b0;
			end else begin
				is_status         <= 1'b1;
				param_value       <= '0;
				param_index       <= '0;
				outcome           <= job_q.outcome;
				reply_id          <= job_q.id;
				reply_param_count <= job_q.count;
				reply_checksum    <= job_q.checksum;
				last              <= 1'b1;
			end
		end
	end

endmodule

/* src/servo_bus_response_deframer.sv */
// ----------------------------------------------------------------------------
// servo_bus_response_deframer
// Parses servo bus replies and reports parameter bytes and a final status.
// ----------------------------------------------------------------------------
// Throughput: one input item per cycle while the two-entry job queue has room.
// A finishing item goes through the job queue and the job register to the output
// register; then one result per cycle while out_ready allows (params, then status).
// Reset: asynchronous, active low; returns to idle, empties the queue and sets
// timeout_ticks to 100.
module servo_bus_response_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbrd_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [7:0]                    rx_byte,
	input  logic [7:0]                    expected_command,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          is_status,
	output logic [7:0]                    param_value,
	output logic [sbrd_pkg::PIDX_W-1:0]   param_index,
	output logic [1:0]                    outcome,
	output logic [7:0]                    reply_id,
	output logic [sbrd_pkg::PCNT_W-1:0]   reply_param_count,
	output logic [7:0]                    reply_checksum,
	output logic                          last
);

	logic [15:0]    timeout_ticks_q;
	logic           reg_hit;
	logic           q_full;
	logic           push;
	logic           pop;
	logic           q_valid;
	sbrd_pkg::job_t wr_job;
	sbrd_pkg::job_t rd_job;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[sbrd_pkg::ADDR_W-1:2] == sbrd_pkg::REG_TIMEOUT);
	assign prdata  = reg_hit ? {16'd0, timeout_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= sbrd_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			timeout_ticks_q <= pwdata[15:0];
		end
	end

	sbrd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.rx_byte          (rx_byte),
		.expected_command (expected_command),
		.timeout_ticks    (timeout_ticks_q),
		.q_full           (q_full),
		.push             (push),
		.job              (wr_job)
	);

	sbrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (wr_job),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_job   (rd_job)
	);

	sbrd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_job             (rd_job),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.is_status         (is_status),
		.param_value       (param_value),
		.param_index       (param_index),
		.outcome           (outcome),
		.reply_id          (reply_id),
		.reply_param_count (reply_param_count),
		.reply_checksum    (reply_checksum),
		.last              (last)
	);

endmodule

/* tb/sv/servo_bus_response_deframer_tb.sv */
// ----------------------------------------------------------------------------
// servo_bus_response_deframer_tb
// Self-checking bench for the servo bus reply deframer. Requests are sent
// through the valid/ready input port and a built-in deframer predictor works
// out every parameter and status result. Each result that leaves the block is
// checked against the oldest prediction. The timeout register is set through
// the APB port between traffic phases, and both ports stall at random.
// ----------------------------------------------------------------------------
module servo_bus_response_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0]                  ACT_UNUSED   = 2'd3;
	localparam logic [sbrd_pkg::ADDR_W-1:0] TIMEOUT_ADDR =
		sbrd_pkg::ADDR_W'(4 * int'(sbrd_pkg::REG_TIMEOUT));
	localparam int                          DRAIN_TAIL   = 16;
	localparam int                          STALL_LIMIT  = 3000;
	localparam int                          TICK_PCT     = 10;

	typedef struct packed {
		logic                        is_status;
		logic [7:0]                  value;
		logic [sbrd_pkg::PIDX_W-1:0] index;
		sbrd_pkg::outcome_t          outcome;
		logic [7:0]                  id;
		logic [sbrd_pkg::PCNT_W-1:0] count;
		logic [7:0]                  checksum;
		logic                        last;
	} reply_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [sbrd_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                   pwdata;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic [1:0]                    action;
	logic [7:0]                    rx_byte;
	logic [7:0]                    expected_command;
	logic                          out_valid;
	logic                          out_ready;
	logic                          is_status;
	logic [7:0]                    param_value;
	logic [sbrd_pkg::PIDX_W-1:0]   param_index;
	logic [1:0]                    outcome;
	logic [7:0]                    reply_id;
	logic [sbrd_pkg::PCNT_W-1:0]   reply_param_count;
	logic [7:0]                    reply_checksum;
	logic                          last;

	// Deframer predictor state.
	sbrd_pkg::phase_t    rx_phase;
	logic [1:0]          sync_run;
	logic [15:0]         phase_ticks;
	logic [15:0]         timeout_limit;
	logic [7:0]          want_cmd;
	logic [7:0]          reply_id_seen;
	logic [7:0]          reply_len_seen;
	logic [7:0]          reply_cmd_seen;
	logic [3:0]          taken;
	logic [7:0]          param_bytes [sbrd_pkg::PARAM_MAX];

	reply_result_t       expected_replies [$];
	reply_result_t       seen_reply;
	logic                in_fire_s;
	logic                out_fire_s;
	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  items_sent;
	int                  mismatch_count;
	int                  quiet_cycles;

	servo_bus_response_deframer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.rx_byte           (rx_byte),
		.expected_command  (expected_command),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.is_status         (is_status),
		.param_value       (param_value),
		.param_index       (param_index),
		.outcome           (outcome),
		.reply_id          (reply_id),
		.reply_param_count (reply_param_count),
		.reply_checksum    (reply_checksum),
		.last              (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic string describe(reply_result_t r);
		return $sformatf("st=%0d val=%02h idx=%0d oc=%0d id=%02h cnt=%0d cs=%02h last=%0d",
			r.is_status, r.value, r.index, r.outcome, r.id, r.count, r.checksum, r.last);
	endfunction

	function automatic void push_status(sbrd_pkg::outcome_t oc,
		logic [sbrd_pkg::PCNT_W-1:0] cnt, logic [7:0] cs);
		reply_result_t r;
		r = '0;
		r.is_status = 1'b1;
		r.outcome   = oc;
		r.id        = reply_id_seen;
		r.count     = cnt;
		r.checksum  = cs;
		r.last      = 1'b1;
		expected_replies.push_back(r);
		rx_phase = sbrd_pkg::PH_IDLE;
	endfunction

	function automatic void predict_reply(logic [1:0] act, logic [7:0] b, logic [7:0] cmd);
		logic [7:0]    plen;
		reply_result_t r;
		plen = reply_len_seen - sbrd_pkg::LEN_OVERHEAD;
		if (act == sbrd_pkg::ACT_START) begin
			rx_phase       = sbrd_pkg::PH_HEADER;
			sync_run       = '0;
			phase_ticks    = '0;
			want_cmd       = cmd;
			reply_id_seen  = '0;
			reply_len_seen = '0;
			reply_cmd_seen = '0;
			taken          = '0;
			return;
		end
		if (rx_phase == sbrd_pkg::PH_IDLE || act == ACT_UNUSED)
			return;
		if (act == sbrd_pkg::ACT_TICK) begin
			if (phase_ticks != 16'hFFFF)
				phase_ticks++;
			if (phase_ticks >= timeout_limit)
				push_status(sbrd_pkg::OUT_TIMEOUT, '0, '0);
			return;
		end
		case (rx_phase)
			sbrd_pkg::PH_HEADER: begin
				if (b == sbrd_pkg::SYNC_BYTE) begin
					sync_run++;
					if (sync_run >= 2) begin
						rx_phase    = sbrd_pkg::PH_HEAD;
						phase_ticks = '0;
						taken       = '0;
					end
				end else begin
					sync_run = '0;
				end
			end
			sbrd_pkg::PH_HEAD: begin
				if (taken == 0) begin
					reply_id_seen = b;
					taken = 1;
				end else if (taken == 1) begin
					reply_len_seen = b;
					taken = 2;
				end else begin
					reply_cmd_seen = b;
					plen = reply_len_seen - sbrd_pkg::LEN_OVERHEAD;
					if (plen > sbrd_pkg::PARAM_MAX) begin
						push_status(sbrd_pkg::OUT_BADLEN, '0, '0);
					end else begin
						rx_phase    = sbrd_pkg::PH_BODY;
						phase_ticks = '0;
						taken       = '0;
					end
				end
			end
			sbrd_pkg::PH_BODY: begin
				if (taken < plen) begin
					param_bytes[taken] = b;
					taken++;
				end else if (reply_cmd_seen != want_cmd) begin
					push_status(sbrd_pkg::OUT_MISMATCH, '0, b);
				end else begin
					for (int i = 0; i < plen; i++) begin
						r = '0;
						r.value = param_bytes[i];
						r.index = sbrd_pkg::PIDX_W'(i);
						expected_replies.push_back(r);
					end
					push_status(sbrd_pkg::OUT_OK, sbrd_pkg::PCNT_W'(plen), b);
				end
			end
			default: ;
		endcase
	endfunction

	// Called just after a rising edge; returns just after the edge that took the request.
	task automatic send_request(input logic [1:0] act, input logic [7:0] b, input logic [7:0] cmd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		action           <= act;
		rx_byte          <= b;
		expected_command <= cmd;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		predict_reply(act, b, cmd);
		items_sent++;
	endtask

	// A received byte, now and then preceded by a timer tick.
	task automatic send_rx(input logic [7:0] b);
		if ($urandom_range(99) < TICK_PCT)
			send_request(sbrd_pkg::ACT_TICK, 8'($urandom), 8'($urandom));
		send_request(sbrd_pkg::ACT_BYTE, b, 8'($urandom));
	endtask

	task automatic drain_replies();
		in_valid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic reg_write(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TIMEOUT_ADDR;
		pwdata  <= {16'h0000, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		timeout_limit = value;
	endtask

	task automatic check_timeout_register(input logic [15:0] want);
		logic [31:0] data;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= TIMEOUT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		data = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (data !== {16'h0000, want}) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("timeout_ticks readback: expected %0d, got %0d", want, data);
		end
	endtask

	task automatic program_timeout(input logic [15:0] ticks);
		drain_replies();
		reg_write(ticks);
		check_timeout_register(ticks);
	endtask

	task automatic test_reset_value_and_idle_input();
		check_timeout_register(sbrd_pkg::TIMEOUT_RESET);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'hFF);
		send_request(sbrd_pkg::ACT_TICK, 8'hFF, 8'h00);
		send_request(ACT_UNUSED, 8'h00, 8'hFF);
	endtask

	task automatic test_full_reply();
		send_request(sbrd_pkg::ACT_START, 8'h00, 8'hA5);
		// A lone sync byte followed by another byte restarts the hunt.
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'h00, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'hFE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'(sbrd_pkg::PARAM_MAX + 3), 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'hA5, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'h00, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'hFF, 8'h00);
		for (int i = 2; i < sbrd_pkg::PARAM_MAX; i++)
			send_request(sbrd_pkg::ACT_BYTE, 8'(i * 8'h2B), 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'hFF, 8'h00);
	endtask

	task automatic test_mismatch_and_bad_length();
		logic [7:0] mismatch_frame [$];
		logic [7:0] empty_frame [$];
		mismatch_frame = '{sbrd_pkg::SYNC_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00, 8'h03,
			8'h00, 8'h00};
		empty_frame    = '{sbrd_pkg::SYNC_BYTE, sbrd_pkg::SYNC_BYTE, 8'h7F, 8'h03,
			8'hFF, 8'hFF};
		send_request(sbrd_pkg::ACT_START, 8'hFF, 8'hFF);
		foreach (mismatch_frame[i])
			send_request(sbrd_pkg::ACT_BYTE, mismatch_frame[i], 8'h00);
		send_request(sbrd_pkg::ACT_START, 8'h00, 8'hFF);
		foreach (empty_frame[i])
			send_request(sbrd_pkg::ACT_BYTE, empty_frame[i], 8'h00);
		// A length below three wraps around to a huge parameter count.
		send_request(sbrd_pkg::ACT_START, 8'h00, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'h01, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'h02, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'h00, 8'h00);
	endtask

	task automatic test_restart_and_timeout();
		program_timeout(16'd1);
		send_request(sbrd_pkg::ACT_START, 8'h00, 8'h12);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		// A second start drops the first transaction, including its sync count.
		send_request(sbrd_pkg::ACT_START, 8'h00, 8'h34);
		send_request(ACT_UNUSED, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, 8'h09, 8'h00);
		send_request(sbrd_pkg::ACT_TICK, 8'h00, 8'h00);
	endtask

	task automatic random_reply_traffic(input int n_items);
		logic [7:0] frame [$];
		logic [7:0] cmd;
		logic [7:0] len;
		int         stop_at;
		int         kind;
		int         cut;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			kind = $urandom_range(99);
			if (kind >= 85) begin
				repeat ($urandom_range(1, 4))
					send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
			end else begin
				cmd = 8'($urandom);
				send_request(sbrd_pkg::ACT_START, 8'($urandom), cmd);
				if ($urandom_range(99) < 20)
					repeat ($urandom_range(1, 3)) send_rx(8'($urandom));
				if ($urandom_range(99) < 85)
					len = 8'($urandom_range(3, 3 + sbrd_pkg::PARAM_MAX));
				else if ($urandom_range(1) == 1)
					len = 8'($urandom_range(0, 2));
				else
					len = 8'($urandom_range(4 + sbrd_pkg::PARAM_MAX, 255));
				frame = '{sbrd_pkg::SYNC_BYTE, sbrd_pkg::SYNC_BYTE, 8'($urandom), len,
					($urandom_range(99) < 75) ? cmd : 8'($urandom)};
				if (8'(len - sbrd_pkg::LEN_OVERHEAD) <= sbrd_pkg::PARAM_MAX) begin
					repeat (len - sbrd_pkg::LEN_OVERHEAD) frame.push_back(8'($urandom));
					frame.push_back(8'($urandom));
				end
				// Timeout runs stop part way through the frame and let the ticks run out.
				if (kind >= 70)
					cut = $urandom_range(0, frame.size() - 1);
				else if ($urandom_range(99) < 5)
					cut = $urandom_range(1, frame.size() - 1);
				else
					cut = frame.size();
				for (int i = 0; i < cut; i++)
					send_rx(frame[i]);
				if (kind >= 70)
					repeat ((timeout_limit > 40) ? 40 : timeout_limit)
						send_request(sbrd_pkg::ACT_TICK, 8'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic test_phase_timer_restart();
		program_timeout(16'd15);
		send_request(sbrd_pkg::ACT_START, 8'h00, 8'h3C);
		// Ticks in the hunt phase must not carry over into the next phase.
		repeat (12) send_request(sbrd_pkg::ACT_TICK, 8'h00, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		send_request(sbrd_pkg::ACT_BYTE, sbrd_pkg::SYNC_BYTE, 8'h00);
		repeat (15) send_request(sbrd_pkg::ACT_TICK, 8'h00, 8'h00);
	endtask

	always @(negedge clk) begin
		in_fire_s  = arst_n && in_valid && in_ready;
		out_fire_s = arst_n && out_valid && out_ready;
		seen_reply.is_status = is_status;
		seen_reply.value     = param_value;
		seen_reply.index     = param_index;
		seen_reply.outcome   = sbrd_pkg::outcome_t'(outcome);
		seen_reply.id        = reply_id;
		seen_reply.count     = reply_param_count;
		seen_reply.checksum  = reply_checksum;
		seen_reply.last      = last;
	end

	always @(posedge clk) begin
		reply_result_t want;
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if (out_fire_s) begin
			if (expected_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %s", describe(seen_reply));
			end else begin
				want = expected_replies.pop_front();
				if (seen_reply !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %s, got %s",
							describe(want), describe(seen_reply));
				end
			end
		end
		if (in_fire_s || out_fire_s || psel || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		in_valid         = 1'b0;
		action           = sbrd_pkg::ACT_TICK;
		rx_byte          = '0;
		expected_command = '0;
		out_ready        = 1'b0;
		in_fire_s        = 1'b0;
		out_fire_s       = 1'b0;
		items_sent       = 0;
		mismatch_count   = 0;
		quiet_cycles     = 0;
		send_idle_pct    = 26;
		recv_stall_pct   = 69;
		rx_phase         = sbrd_pkg::PH_IDLE;
		sync_run         = '0;
		phase_ticks      = '0;
		timeout_limit    = sbrd_pkg::TIMEOUT_RESET;
		want_cmd         = '0;
		reply_id_seen    = '0;
		reply_len_seen   = '0;
		reply_cmd_seen   = '0;
		taken            = '0;
		arst_n           = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_value_and_idle_input();
		test_full_reply();
		test_mismatch_and_bad_length();
		test_restart_and_timeout();
		program_timeout(16'd6);
		random_reply_traffic(60);

		send_idle_pct  = 69;
		recv_stall_pct = 26;
		program_timeout(16'($urandom_range(2, 40)));
		random_reply_traffic(60);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		program_timeout(16'd20);
		random_reply_traffic(60);
		test_phase_timer_restart();

		drain_replies();
		if (mismatch_count == 0 && expected_replies.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
